FILE: rtl/core/dmlp_pkg.sv
// Package for the debounced mode lamp pattern generator.
// Holds its constants, register indexes, the result type and the lamp step tables.
// It depends on nothing else.
package dmlp_pkg;

  // Widths of the configuration registers and of the internal counters.
  localparam int unsigned CfgWidth      = 16;
  localparam int unsigned DebAgeWidth   = 17;
  localparam int unsigned FlashAgeWidth = 16;
  localparam int unsigned StepWidth     = 4;
  localparam int unsigned PatternWidth  = 3;
  localparam int unsigned LampCount     = 3;

  // Reset values of the configuration registers.
  localparam logic [CfgWidth-1:0] DebounceDelayReset = 16'd50;
  localparam logic [CfgWidth-1:0] FlashIntervalReset = 16'd500;

  // Pattern codes.
  localparam logic [PatternWidth-1:0] PatOff     = 3'd0;
  localparam logic [PatternWidth-1:0] PatOn      = 3'd1;
  localparam logic [PatternWidth-1:0] PatToggle  = 3'd2;
  localparam logic [PatternWidth-1:0] PatShort   = 3'd3;
  localparam logic [PatternWidth-1:0] PatLong    = 3'd4;

  // Step wrap points: a step count that would reach these restarts at one.
  localparam logic [StepWidth-1:0] ShortWrap = 4'd5;
  localparam logic [StepWidth-1:0] LongWrap  = 4'd9;
  localparam logic [StepWidth-1:0] StepFirst = 4'd1;

  // Configuration register indexes.
  typedef enum logic {
    RegDebounceDelay = 1'b0,
    RegFlashInterval = 1'b1
  } cfg_reg_e;

  // One result item: lamps with bit 2 as lamp one, and the pattern number.
  typedef struct packed {
    logic [LampCount-1:0]    lamps;
    logic [PatternWidth-1:0] pattern;
  } result_t;

  // Four-step sequence of the short pattern.
  function automatic logic [LampCount-1:0] short_seq_lamps(input logic [StepWidth-1:0] step);
    logic [LampCount-1:0] lamps;
    case (step)
      4'd1:    lamps = 3'b100;
      4'd2:    lamps = 3'b010;
      4'd3:    lamps = 3'b110;
      4'd4:    lamps = 3'b001;
      default: lamps = 3'b000;
    endcase
    return lamps;
  endfunction

  // Eight-step sequence of the long pattern; even steps are dark.
  function automatic logic [LampCount-1:0] long_seq_lamps(input logic [StepWidth-1:0] step);
    logic [LampCount-1:0] lamps;
    case (step)
      4'd1, 4'd3: lamps = 3'b101;
      4'd5, 4'd7: lamps = 3'b011;
      default:    lamps = 3'b000;
    endcase
    return lamps;
  endfunction

endpackage

FILE: rtl/core/debounced_mode_lamp_pattern_generator.sv
// Top level of the debounced mode lamp pattern generator.
// Debounces the button, selects the pattern and drives three lamps.
// Depends on dmlp_pkg.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------------------
//   in       | in_valid_i / in_ready_o     | button_level_i
//   out      | out_valid_o / out_ready_i   | lamp_one_o, lamp_two_o, lamp_three_o,
//            |                             | pattern_index_o
//   cfg      | cfg_we_i (no wait)          | cfg_index_i, cfg_data_i
//
// The state update is computed from the state registers and the input in one pass and
// is registered with the result, which goes to the skid register while a waiting
// result is not taken, else to the output register. A new tick is taken every cycle;
// the input stalls only while both output entries are full. A two-entry output buffer
// (output register plus skid register) keeps the input open for one more transaction
// while a result waits. Reset clears the tick state and the valid flags.
module debounced_mode_lamp_pattern_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        button_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        lamp_one_o,
  output logic        lamp_two_o,
  output logic        lamp_three_o,
  output logic [2:0]  pattern_index_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers.
  logic [dmlp_pkg::CfgWidth-1:0] deb_limit_q;
  logic [dmlp_pkg::CfgWidth-1:0] flash_period_q;

  // Tick state.
  logic                                 prev_sample_q, prev_sample_d;
  logic                                 stable_level_q, stable_level_d;
  logic [dmlp_pkg::DebAgeWidth-1:0]     deb_age_q, deb_age_d;
  logic [dmlp_pkg::PatternWidth-1:0]    pattern_q, pattern_d;
  logic [dmlp_pkg::FlashAgeWidth-1:0]   flash_age_q, flash_age_d;
  logic [dmlp_pkg::LampCount-1:0]       toggle_lamps_q, toggle_lamps_d;
  logic [dmlp_pkg::StepWidth-1:0]       step_q, step_d;
  logic [dmlp_pkg::LampCount-1:0]       lamp_drive_q, lamp_drive_d;

  // Output buffer.
  logic              out_valid_q;
  logic              skid_valid_q;
  dmlp_pkg::result_t out_q;
  dmlp_pkg::result_t skid_q;
  dmlp_pkg::result_t result;

  logic in_fire;
  logic out_fire;
  logic out_load;

  // Intermediate values of the tick update.
  logic [dmlp_pkg::PatternWidth-1:0]  pattern_sel;
  logic [dmlp_pkg::FlashAgeWidth-1:0] flash_inc;
  logic                               flash_due;
  logic [dmlp_pkg::StepWidth-1:0]     step_inc;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign out_load   = out_fire || !out_valid_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_limit_q    <= dmlp_pkg::DebounceDelayReset;
      flash_period_q <= dmlp_pkg::FlashIntervalReset;
    end else if (cfg_we_i) begin
      case (dmlp_pkg::cfg_reg_e'(cfg_index_i))
        dmlp_pkg::RegDebounceDelay: deb_limit_q <= cfg_data_i;
        dmlp_pkg::RegFlashInterval: flash_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Debounce and pattern selection.
  always_comb begin
    if (button_level_i != prev_sample_q) begin
      deb_age_d = '0;
    end else if (deb_age_q != '1) begin
      deb_age_d = deb_age_q + 1'b1;
    end else begin
      deb_age_d = deb_age_q;
    end
    stable_level_d = stable_level_q;
    pattern_sel    = pattern_q;
    if ((deb_age_d > {1'b0, deb_limit_q}) && (button_level_i != stable_level_q)) begin
      stable_level_d = button_level_i;
      if (button_level_i) begin
        pattern_sel = (pattern_q == dmlp_pkg::PatLong) ? dmlp_pkg::PatOff : pattern_q + 1'b1;
      end
    end
    prev_sample_d = button_level_i;
  end

  // Lamp drive for the pattern now in force.
  always_comb begin
    flash_inc      = (flash_age_q != '1) ? flash_age_q + 1'b1 : flash_age_q;
    flash_due      = flash_inc >= flash_period_q;
    step_inc       = step_q + 1'b1;
    flash_age_d    = flash_inc;
    toggle_lamps_d = toggle_lamps_q;
    step_d         = step_q;
    lamp_drive_d   = lamp_drive_q;
    pattern_d      = pattern_sel;
    case (pattern_sel)
      dmlp_pkg::PatOff: begin
        lamp_drive_d = '0;
      end
      dmlp_pkg::PatOn: begin
        lamp_drive_d = '1;
      end
      dmlp_pkg::PatToggle: begin
        if (flash_due) begin
          flash_age_d    = '0;
          toggle_lamps_d = ~toggle_lamps_q;
          lamp_drive_d   = ~toggle_lamps_q;
        end
      end
      dmlp_pkg::PatShort: begin
        if (flash_due) begin
          flash_age_d  = '0;
          lamp_drive_d = dmlp_pkg::short_seq_lamps(step_q);
          step_d = (step_inc == dmlp_pkg::ShortWrap) ? dmlp_pkg::StepFirst : step_inc;
        end
      end
      dmlp_pkg::PatLong: begin
        if (flash_due) begin
          flash_age_d  = '0;
          lamp_drive_d = dmlp_pkg::long_seq_lamps(step_q);
          step_d = (step_inc == dmlp_pkg::LongWrap) ? dmlp_pkg::StepFirst : step_inc;
        end
      end
      default: begin
        // Codes above the last pattern fall back to all off; the lamps hold.
        pattern_d = dmlp_pkg::PatOff;
      end
    endcase
    result.lamps   = lamp_drive_d;
    result.pattern = pattern_d;
  end

  // Tick state registers, updated on each input transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sample_q  <= 1'b0;
      stable_level_q <= 1'b0;
      deb_age_q      <= '0;
      pattern_q      <= dmlp_pkg::PatOff;
      flash_age_q    <= '0;
      toggle_lamps_q <= '0;
      step_q         <= dmlp_pkg::StepFirst;
      lamp_drive_q   <= '0;
    end else if (in_fire) begin
      prev_sample_q  <= prev_sample_d;
      stable_level_q <= stable_level_d;
      deb_age_q      <= deb_age_d;
      pattern_q      <= pattern_d;
      flash_age_q    <= flash_age_d;
      toggle_lamps_q <= toggle_lamps_d;
      step_q         <= step_d;
      lamp_drive_q   <= lamp_drive_d;
    end
  end

  // Output register and skid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q  <= skid_valid_q || in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload of the output buffer.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (in_fire) begin
      skid_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign lamp_one_o      = out_q.lamps[2];
  assign lamp_two_o      = out_q.lamps[1];
  assign lamp_three_o    = out_q.lamps[0];
  assign pattern_index_o = out_q.pattern;

  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  // The selected pattern never leaves the range of defined patterns.
  a_pattern_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pattern_q <= dmlp_pkg::PatLong)
    else $error("pattern register holds an undefined pattern");

  // A transaction taken into an empty buffer shows up at the output next cycle.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_valid_q) |=> (out_valid_q && !skid_valid_q))
    else $error("accepted tick did not produce a result");

endmodule

FILE: sim/dmlp_lamp_checker.sv
// Checker for the debounced mode lamp pattern generator: watches the tick, result and
// register ports, predicts every result and compares it with what the block returns.
// Depends on dmlp_pkg.
`timescale 1ns / 100ps

module dmlp_lamp_checker
  import dmlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        button_level_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        lamp_one_i,
  input  logic        lamp_two_i,
  input  logic        lamp_three_i,
  input  logic [2:0]  pattern_index_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int ReportLimit = 10;
  localparam logic [DebAgeWidth-1:0]   DebAgeMax   = '1;
  localparam logic [FlashAgeWidth-1:0] FlashAgeMax = '1;

  // Lamp words per step, three bits per entry with step 0 in the lowest bits.
  // Steps outside a sequence show all lamps dark.
  localparam logic [47:0] ShortStepLamps = {33'b0, 3'b001, 3'b110, 3'b010, 3'b100, 3'b000};
  localparam logic [47:0] LongStepLamps  = {24'b0, 3'b011, 3'b000, 3'b011, 3'b000,
                                            3'b101, 3'b000, 3'b101, 3'b000};

  // Private copy of the block's registers and state.
  logic [CfgWidth-1:0]      deb_limit;
  logic [CfgWidth-1:0]      flash_period;
  logic                     last_raw;
  logic                     accepted_level;
  logic [DebAgeWidth-1:0]   level_age;
  logic [PatternWidth-1:0]  cur_pattern;
  logic [FlashAgeWidth-1:0] since_flash;
  logic [LampCount-1:0]     toggle_word;
  logic [StepWidth-1:0]     step_cnt;
  logic [LampCount-1:0]     lamp_word;

  result_t lamp_expect_q[$];
  result_t want;

  // Advances the private state by one tick and returns the lamps and pattern it shows.
  task automatic predict_tick(input logic raw, output result_t res);
    logic                 due;
    logic [StepWidth-1:0] next_step;
    // Debounce: a change restarts the age, a stable level ages until it saturates.
    if (raw != last_raw) level_age = '0;
    else if (level_age != DebAgeMax) level_age = level_age + 1'b1;
    if (level_age > {1'b0, deb_limit} && raw != accepted_level) begin
      accepted_level = raw;
      if (raw) cur_pattern = (cur_pattern == PatLong) ? PatOff : cur_pattern + 1'b1;
    end
    last_raw = raw;

    // The flash age runs in every pattern but is cleared only by the flashing ones.
    if (since_flash != FlashAgeMax) since_flash = since_flash + 1'b1;
    due = (since_flash >= flash_period);

    case (cur_pattern)
      PatOff: begin
        lamp_word = 3'b000;
      end
      PatOn: begin
        lamp_word = 3'b111;
      end
      PatToggle: begin
        if (due) begin
          since_flash = '0;
          toggle_word = ~toggle_word;
          lamp_word = toggle_word;
        end
      end
      PatShort: begin
        if (due) begin
          since_flash = '0;
          lamp_word = ShortStepLamps[step_cnt*3 +: 3];
          next_step = step_cnt + 1'b1;
          step_cnt = (next_step == ShortWrap) ? StepFirst : next_step;
        end
      end
      PatLong: begin
        if (due) begin
          since_flash = '0;
          lamp_word = LongStepLamps[step_cnt*3 +: 3];
          next_step = step_cnt + 1'b1;
          step_cnt = (next_step == LongWrap) ? StepFirst : next_step;
        end
      end
      default: begin
        cur_pattern = PatOff;
      end
    endcase

    res.lamps = lamp_word;
    res.pattern = cur_pattern;
  endtask

  // Counts a failure and reports only the first few.
  task automatic note_failure(input string what);
    fail_count_o++;
    if (fail_count_o <= ReportLimit) begin
      $display("%0t: %s: expected lamps %b pattern %0d, got lamps %b pattern %0d",
               $realtime, what, want.lamps, want.pattern,
               {lamp_one_i, lamp_two_i, lamp_three_i}, pattern_index_i);
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  // Everything is sampled at the rising edge, where the stimulus is stable.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_limit = DebounceDelayReset;
      flash_period = FlashIntervalReset;
      last_raw = 1'b0;
      accepted_level = 1'b0;
      level_age = '0;
      cur_pattern = PatOff;
      since_flash = '0;
      toggle_word = '0;
      step_cnt = StepFirst;
      lamp_word = '0;
      lamp_expect_q.delete();
    end else begin
      // Register writes.
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegDebounceDelay: deb_limit = cfg_data_i;
          RegFlashInterval: flash_period = cfg_data_i;
          default: ;
        endcase
      end

      // Result transaction: compare with the oldest expectation.
      if (out_valid_i && out_ready_i) begin
        if (lamp_expect_q.size() == 0) begin
          want = '0;
          note_failure("result with nothing expected");
        end else begin
          want = lamp_expect_q.pop_front();
          if (lamp_one_i !== want.lamps[2] || lamp_two_i !== want.lamps[1] ||
              lamp_three_i !== want.lamps[0] || pattern_index_i !== want.pattern) begin
            note_failure("result mismatch");
          end
        end
      end

      // Tick transaction: predict its result.
      if (in_valid_i && in_ready_i) begin
        predict_tick(button_level_i, want);
        lamp_expect_q.push_back(want);
      end
    end
    pending_o = lamp_expect_q.size();
  end

endmodule

FILE: sim/tb.sv
// Top of the testbench for the debounced mode lamp pattern generator: clock, reset,
// button stimulus, register writes and the verdict. Depends on dmlp_pkg,
// dmlp_lamp_checker and the block itself.
`timescale 1ns / 100ps

module tb;
  import dmlp_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int PhaseItems   = 40;
  localparam int SettleCycles = 4;
  localparam int FastDebounce = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        button_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        lamp_one_o;
  logic        lamp_two_o;
  logic        lamp_three_o;
  logic [2:0]  pattern_index_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = RegDebounceDelay;
  logic [15:0] cfg_data_i = '0;

  int          fail_count;
  int          pending;
  int          stall_cycles = 0;
  int          ticks_sent = 0;
  logic        steady = 1'b0;
  logic [15:0] deb_now = DebounceDelayReset;

  always #4 clk_i = ~clk_i;

  debounced_mode_lamp_pattern_generator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .button_level_i  (button_level_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lamp_one_o      (lamp_one_o),
    .lamp_two_o      (lamp_two_o),
    .lamp_three_o    (lamp_three_o),
    .pattern_index_o (pattern_index_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  dmlp_lamp_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .button_level_i  (button_level_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lamp_one_i      (lamp_one_o),
    .lamp_two_i      (lamp_two_o),
    .lamp_three_i    (lamp_three_o),
    .pattern_index_i (pattern_index_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // The result side stalls about a third of the time, except in the steady stretch.
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 33);
  end

  // Watchdog: cycles since the last transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("tb NOT OK");
    $finish;
  end

  // Sends one tick with the given button level; entered and left at a falling edge.
  task automatic send_tick(input logic lvl);
    if (!steady && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while (!steady && $urandom_range(99) < 33) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    button_level_i <= lvl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  task automatic hold_level(input logic lvl, input int count);
    repeat (count) send_tick(lvl);
  endtask

  // Lets every outstanding result come back, then idles before returning.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == RegDebounceDelay) deb_now = value;
  endtask

  task automatic set_config(input logic [15:0] deb, input logic [15:0] flash);
    settle();
    write_reg(RegDebounceDelay, deb);
    write_reg(RegFlashInterval, flash);
  endtask

  // Hold time around a small debounce threshold: one tick short, exact, or one over.
  function automatic int hold_span();
    if (deb_now <= FastDebounce) return deb_now + 1 + $urandom_range(2);
    return $urandom_range(1, 6);
  endfunction

  // One button press, sometimes preceded by a bounce too short to be accepted.
  task automatic press_button();
    if ($urandom_range(3) == 0 && deb_now != 0 && deb_now <= FastDebounce) begin
      hold_level(1'b1, $urandom_range(1, deb_now));
      hold_level(1'b0, $urandom_range(1, deb_now));
    end
    hold_level(1'b1, hold_span());
    hold_level(1'b0, hold_span());
  endtask

  // Mostly clean presses with random timing, the rest random button noise.
  task automatic run_ticks(input int count);
    int start;
    start = ticks_sent;
    while (ticks_sent - start < count) begin
      if ($urandom_range(9) < 7) press_button();
      else repeat ($urandom_range(1, 8)) send_tick($urandom_range(1) != 0);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: a short press is far below the default debounce delay.
    hold_level(1'b1, 2);
    hold_level(1'b0, 1);

    // Zero delay and zero interval: a one-tick bounce is rejected, then six clean
    // presses walk through every pattern and back to all lamps on.
    set_config(16'd0, 16'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    repeat (6) begin
      hold_level(1'b1, 2);
      hold_level(1'b0, 2);
    end

    // Largest delay: a long held press is still far from acceptance, so the
    // pattern stays where it is.
    set_config(16'hFFFF, 16'd2);
    hold_level(1'b1, 24);
    hold_level(1'b0, 4);

    // Random part over several settings.
    set_config(16'd0, 16'd1);
    run_ticks(PhaseItems);
    set_config(16'd2, 16'd3);
    run_ticks(PhaseItems);
    set_config(16'd1, 16'd2);
    steady = 1'b1;
    run_ticks(PhaseItems);
    steady = 1'b0;
    set_config(16'hFFFF, 16'd1);
    run_ticks(20);
    set_config(16'd4, 16'hFFFF);
    run_ticks(PhaseItems);
    repeat (4) begin
      set_config(16'($urandom_range(0, 6)), 16'($urandom_range(1, 5)));
      run_ticks(PhaseItems);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
